/* src/s_curve_step_table_entry_top_macros.svh */
// Assertion macros used by the checker file of the S-curve table block.
// Depends on nothing; include by bare file name.
`ifndef S_CURVE_STEP_TABLE_ENTRY_TOP_MACROS_SVH
`define S_CURVE_STEP_TABLE_ENTRY_TOP_MACROS_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define SCSTE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is also checked while reset is asserted.
`define SCSTE_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/scste_pkg.sv */
// Package of the S-curve step table block: widths, field positions, codes,
// pipeline stage map and the pipeline record. Depends on nothing.
package scste_pkg;

    localparam int RISE_SEG_LOG2 = 4;
    localparam int HOLD_SEG_LOG2 = 4;
    localparam int FALL_SEG_LOG2 = 4;
    localparam int RISE_SEGMENTS = 1 << RISE_SEG_LOG2;
    localparam int HOLD_SEGMENTS = 1 << HOLD_SEG_LOG2;
    localparam int FALL_SEGMENTS = 1 << FALL_SEG_LOG2;
    localparam int TOTAL_SEGS    = RISE_SEGMENTS + HOLD_SEGMENTS + FALL_SEGMENTS;
    localparam int J_W           = $clog2(TOTAL_SEGS + 1);

    localparam int IDX_W      = 7;
    localparam int PERIOD_W   = 16;
    localparam int STEP_W     = 24;
    localparam int FREQ_W     = 28;
    localparam int TIME_W     = 24;
    localparam int JERK_W     = 32;
    localparam int CLK_W      = 32;
    localparam int DIV_W      = 16;
    localparam int RATE_W     = 40;
    localparam int SQ_W       = 48;
    localparam int PREM_W     = 44;
    localparam int BASE_W     = 50;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int PERIOD_LSB = IDX_W;
    localparam int STEP_LSB   = IDX_W + PERIOD_W;
    localparam int RES_W      = IDX_W + PERIOD_W + STEP_W;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 48;

    localparam logic [FREQ_W-1:0]   FREQ_MAX   = '1;
    localparam logic [PERIOD_W-1:0] PERIOD_MAX = '1;

    // Stage map of the entry pipeline.
    localparam int ST_IN      = 0;
    localparam int ST_RATE    = 1;
    localparam int ST_SQ      = 2;
    localparam int ST_QDIV0   = 3;
    localparam int ST_MUL     = ST_QDIV0 + TIME_W;
    localparam int ST_SUM     = ST_MUL + 1;
    localparam int ST_FD      = ST_SUM + 1;
    localparam int ST_DIV0    = ST_FD + 1;
    localparam int ST_LAST    = ST_DIV0 + STEP_W - 1;
    localparam int NUM_STAGES = ST_LAST + 1;

    typedef enum logic [1:0] {
        PH_RISE,
        PH_HOLD,
        PH_FALL
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_FREQ,
        CFG_JERK,
        CFG_RISE_TIME,
        CFG_HOLD_TIME,
        CFG_FALL_TIME,
        CFG_TIMER_CLOCK,
        CFG_STEP_DIVISOR
    } cfg_idx_t;

    typedef struct packed {
        logic [IDX_W-1:0]    idx;
        phase_t              ph;
        logic                fin;
        logic [TIME_W-1:0]   t;
        logic [TIME_W-1:0]   dur;
        logic [RATE_W-1:0]   rate;
        logic [TIME_W-1:0]   opnd;
        logic [SQ_W-1:0]     rem;
        logic [TIME_W-1:0]   quo;
        logic [55:0]         lo;
        logic [31:0]         hi;
        logic [FREQ_W-1:0]   freq;
        logic [PREM_W-1:0]   prem;
        logic [PERIOD_W-1:0] pquo;
        logic                psat;
        logic [STEP_W-1:0]   srem;
        logic [STEP_W-1:0]   squo;
    } pipe_t;

endpackage

/* src/s_curve_step_table_entry_top.sv */
// Top level of the S-curve step table block: config registers, derived
// profile constants, entry pipeline and output skid stage. Uses scste_pkg.

// One table entry is accepted per cycle while s_tready is high; it passes through
// 54 pipeline stages and then the output register, and the depth is set by the three bit-per-stage
// dividers (fall quadratic, step count, timer period). A stalled output holds
// two results (output register and skid) before s_tready drops. Config writes
// take effect for every entry accepted after the write; constants derived from
// the config settle well before an entry needs them.
module s_curve_step_table_entry_top
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [scste_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [scste_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // s_tdata, lowest bit up: index[6:0], zero[7]
    input  logic [scste_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // m_tdata, lowest bit up: index_out[6:0], timer_period[22:7],
    // step_count[46:23], zero[47]
    output logic [scste_pkg::M_TDATA_W-1:0]    m_tdata
);
    import scste_pkg::*;

    logic [FREQ_W-1:0]  start_freq_reg;
    logic [JERK_W-1:0]  jerk_reg;
    logic [TIME_W-1:0]  rise_time_reg;
    logic [TIME_W-1:0]  hold_time_reg;
    logic [TIME_W-1:0]  fall_time_reg;
    logic [CLK_W-1:0]   timer_clock_reg;
    logic [DIV_W-1:0]   step_divisor_reg;

    logic [55:0]        arise_p_reg;
    logic [RATE_W-1:0]  arise_reg;
    logic [55:0]        re_lo_reg;
    logic [31:0]        re_hi_reg;
    logic [55:0]        ht_lo_reg;
    logic [31:0]        ht_hi_reg;
    logic [46:0]        rise_end_reg;
    logic [47:0]        hold_term_reg;
    logic [BASE_W-1:0]  base_hold_reg;
    logic [BASE_W-1:0]  base_fall_reg;

    pipe_t              dec_next;
    pipe_t              pipe_reg [NUM_STAGES];
    pipe_t              pipe_next [NUM_STAGES];
    logic [NUM_STAGES-1:0] vld_reg;

    logic               out_vld_reg;
    logic [RES_W-1:0]   out_data_reg;
    logic               skid_vld_reg;
    logic [RES_W-1:0]   skid_data_reg;
    logic [RES_W-1:0]   res;
    logic               en;
    logic [DIV_W-1:0]   dv;

    assign en       = !skid_vld_reg;
    assign s_tready = en;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{(M_TDATA_W-RES_W){1'b0}}, out_data_reg};
    assign dv       = (step_divisor_reg == '0) ? DIV_W'(1) : step_divisor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_freq_reg   <= '0;
            jerk_reg         <= '0;
            rise_time_reg    <= '0;
            hold_time_reg    <= '0;
            fall_time_reg    <= TIME_W'(1);
            timer_clock_reg  <= CLK_W'(1000000);
            step_divisor_reg <= DIV_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_START_FREQ:   start_freq_reg   <= cfg_data[FREQ_W-1:0];
                CFG_JERK:         jerk_reg         <= cfg_data[JERK_W-1:0];
                CFG_RISE_TIME:    rise_time_reg    <= cfg_data[TIME_W-1:0];
                CFG_HOLD_TIME:    hold_time_reg    <= cfg_data[TIME_W-1:0];
                CFG_FALL_TIME:    fall_time_reg    <= cfg_data[TIME_W-1:0];
                CFG_TIMER_CLOCK:  timer_clock_reg  <= cfg_data[CLK_W-1:0];
                CFG_STEP_DIVISOR: step_divisor_reg <= cfg_data[DIV_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Free-running chain for the constants that depend on config alone.
    always_ff @(posedge clk)
    begin
        arise_p_reg   <= 56'(jerk_reg) * 56'(rise_time_reg);
        arise_reg     <= arise_p_reg[55:16];
        re_lo_reg     <= 56'(arise_reg[31:0]) * 56'(rise_time_reg);
        re_hi_reg     <= 32'(arise_reg[39:32]) * 32'(rise_time_reg);
        ht_lo_reg     <= 56'(arise_reg[31:0]) * 56'(hold_time_reg);
        ht_hi_reg     <= 32'(arise_reg[39:32]) * 32'(hold_time_reg);
        rise_end_reg  <= 47'((64'(re_lo_reg) + (64'(re_hi_reg) << 32)) >> 17);
        hold_term_reg <= 48'((64'(ht_lo_reg) + (64'(ht_hi_reg) << 32)) >> 16);
        base_hold_reg <= BASE_W'(start_freq_reg) + BASE_W'(rise_end_reg);
        base_fall_reg <= BASE_W'(start_freq_reg) + BASE_W'(rise_end_reg)
                         + BASE_W'(hold_term_reg);
    end

    // Entry decode: clamp, mirror, phase and sample time.
    always_comb
    begin
        logic [IDX_W-1:0]        raw;
        logic [IDX_W-1:0]        ic;
        logic [IDX_W-1:0]        jm;
        logic [J_W-1:0]          j;
        logic [J_W-1:0]          k;
        logic [TIME_W-1:0]       ph_time;
        logic [TIME_W+J_W-1:0]   tprod;
        int                      sh;
        raw = s_tdata[IDX_W-1:0];
        ic  = (raw > IDX_W'(2*TOTAL_SEGS)) ? IDX_W'(2*TOTAL_SEGS) : raw;
        jm  = (ic > IDX_W'(TOTAL_SEGS)) ? IDX_W'(2*TOTAL_SEGS) - ic : ic;
        j   = jm[J_W-1:0];
        dec_next = '0;
        dec_next.idx = raw;
        dec_next.fin = (j == J_W'(TOTAL_SEGS));
        priority if (j < J_W'(RISE_SEGMENTS))
        begin
            dec_next.ph = PH_RISE;
            k       = j;
            ph_time = rise_time_reg;
            sh      = RISE_SEG_LOG2;
        end
        else if (j < J_W'(RISE_SEGMENTS + HOLD_SEGMENTS))
        begin
            dec_next.ph = PH_HOLD;
            k       = j - J_W'(RISE_SEGMENTS);
            ph_time = hold_time_reg;
            sh      = HOLD_SEG_LOG2;
        end
        else
        begin
            dec_next.ph = PH_FALL;
            k       = j - J_W'(RISE_SEGMENTS + HOLD_SEGMENTS);
            ph_time = fall_time_reg;
            sh      = FALL_SEG_LOG2;
        end
        tprod = (TIME_W+J_W)'(ph_time) * (TIME_W+J_W)'(k);
        dec_next.t   = TIME_W'(tprod >> sh);
        dec_next.dur = ph_time;
    end

    // Remaining stages: one step of work each.
    always_comb
    begin
        pipe_t               pr;
        pipe_t               nx;
        logic [55:0]         prod_jt;
        logic [SQ_W-1:0]     qshift;
        logic [RATE_W-1:0]   mcand;
        logic [TIME_W-1:0]   mult;
        logic [63:0]         prod64;
        logic [47:0]         term;
        logic [BASE_W-1:0]   base;
        logic [BASE_W:0]     fsum;
        logic [51:0]         prod_fd;
        logic [39:0]         sshift;
        logic [PREM_W-1:0]   pshift;
        int                  b;
        int                  pb;
        int                  sh;
        pipe_next[ST_IN] = dec_next;
        for (int s = 1; s < NUM_STAGES; s++)
        begin
            pr = pipe_reg[s-1];
            nx = pr;
            priority if (s == ST_RATE)
            begin
                prod_jt = 56'(jerk_reg) * 56'(pr.t);
                nx.rate = prod_jt[55:16];
                nx.opnd = fall_time_reg - pr.t;
            end
            else if (s == ST_SQ)
            begin
                nx.rem = SQ_W'(pr.opnd) * SQ_W'(pr.opnd);
                nx.quo = '0;
            end
            else if (s < ST_MUL)
            begin
                // Restoring division of d*d by fall_time, one quotient bit per stage.
                b      = ST_MUL - 1 - s;
                qshift = SQ_W'(fall_time_reg) << b;
                if (fall_time_reg != '0 && pr.rem >= qshift)
                begin
                    nx.rem    = pr.rem - qshift;
                    nx.quo[b] = 1'b1;
                end
            end
            else if (s == ST_MUL)
            begin
                mcand = (pr.ph == PH_RISE) ? pr.rate : arise_reg;
                mult  = (pr.ph == PH_FALL) ? fall_time_reg - pr.quo : pr.t;
                nx.lo = 56'(mcand[31:0]) * 56'(mult);
                nx.hi = 32'(mcand[39:32]) * 32'(mult);
            end
            else if (s == ST_SUM)
            begin
                prod64 = 64'(pr.lo) + (64'(pr.hi) << 32);
                term   = (pr.ph == PH_HOLD) ? 48'(prod64 >> 16) : 48'(prod64 >> 17);
                unique case (pr.ph)
                    PH_RISE: base = BASE_W'(start_freq_reg);
                    PH_HOLD: base = base_hold_reg;
                    default: base = base_fall_reg;
                endcase
                fsum    = (BASE_W+1)'(base) + (BASE_W+1)'(term);
                nx.freq = (fsum > (BASE_W+1)'(FREQ_MAX)) ? FREQ_MAX : fsum[FREQ_W-1:0];
            end
            else if (s == ST_FD)
            begin
                unique case (pr.ph)
                    PH_RISE: sh = RISE_SEG_LOG2;
                    PH_HOLD: sh = HOLD_SEG_LOG2;
                    default: sh = FALL_SEG_LOG2;
                endcase
                prod_fd = 52'(pr.freq) * 52'(pr.dur);
                nx.srem = STEP_W'(prod_fd[51:24] >> sh);
                nx.squo = '0;
                // The quotient reaches 2^16 exactly when timer_clock*256/2^16 >= f.
                nx.psat = (pr.freq == '0)
                          || (FREQ_W'(timer_clock_reg[CLK_W-1:8]) >= pr.freq);
                nx.prem = PREM_W'({timer_clock_reg, 8'b0});
                nx.pquo = '0;
            end
            else
            begin
                b      = ST_LAST - s;
                sshift = 40'(dv) << b;
                if (40'(pr.srem) >= sshift)
                begin
                    nx.srem    = pr.srem - STEP_W'(sshift);
                    nx.squo[b] = 1'b1;
                end
                if (s < ST_DIV0 + PERIOD_W)
                begin
                    pb     = ST_DIV0 + PERIOD_W - 1 - s;
                    pshift = PREM_W'(pr.freq) << pb;
                    if (pr.prem >= pshift)
                    begin
                        nx.prem     = pr.prem - pshift;
                        nx.pquo[pb] = 1'b1;
                    end
                end
            end
            pipe_next[s] = nx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NUM_STAGES-2:0], s_tvalid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < NUM_STAGES; s++)
            begin
                pipe_reg[s] <= pipe_next[s];
            end
        end
    end

    assign res = {pipe_reg[ST_LAST].fin ? STEP_W'(0) : pipe_reg[ST_LAST].squo,
                  pipe_reg[ST_LAST].psat ? PERIOD_MAX : pipe_reg[ST_LAST].pquo,
                  pipe_reg[ST_LAST].idx};

    // Output register with a skid entry behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (en && vld_reg[ST_LAST])
        begin
            if (!out_vld_reg || m_tready)
            begin
                out_vld_reg <= 1'b1;
            end
            else
            begin
                skid_vld_reg <= 1'b1;
            end
        end
        else if (out_vld_reg && m_tready)
        begin
            out_vld_reg  <= skid_vld_reg;
            skid_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && vld_reg[ST_LAST])
        begin
            if (!out_vld_reg || m_tready)
            begin
                out_data_reg <= res;
            end
            else
            begin
                skid_data_reg <= res;
            end
        end
        else if (out_vld_reg && m_tready && skid_vld_reg)
        begin
            out_data_reg <= skid_data_reg;
        end
    end

endmodule

/* src/scste_checker.sv */
// Port-level checker for the S-curve step table block, bound to the top level.
// Uses scste_pkg and the assertion macros header.
`include "s_curve_step_table_entry_top_macros.svh"

module scste_checker
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tready,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [scste_pkg::M_TDATA_W-1:0]    m_tdata
);
    import scste_pkg::*;

    logic stall;
    logic final_out;
    logic steps_zero;

    assign stall      = m_tvalid && !m_tready;
    assign final_out  = m_tvalid && (m_tdata[IDX_W-1:0] == IDX_W'(TOTAL_SEGS));
    assign steps_zero = (m_tdata[STEP_LSB +: STEP_W] == '0);

    // A result that is not taken stays on the bus unchanged.
    `SCSTE_ASSERT(a_out_hold, clk, rst_n, stall |=> m_tvalid && $stable(m_tdata), "result moved")

    // Reset empties the pipeline and the output stage at once.
    `SCSTE_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |-> !m_tvalid, "result shown during reset")

    // The final-frequency entry runs no steps.
    `SCSTE_ASSERT(a_final_zero, clk, rst_n, final_out |-> steps_zero, "final entry has steps")

    // The input is held off only while the output stage is full.
    `SCSTE_ASSERT(a_ready_full, clk, rst_n, !s_tready |-> m_tvalid, "ready low while empty")

endmodule

bind s_curve_step_table_entry_top scste_checker u_scste_checker (.*);
